@@ rtl/gdmpu_pkg.sv @@
package gdmpu_pkg;

	localparam int GDMPU_ROWS = 64;

	localparam int IN_DATA_W  = 8;
	localparam int OUT_DATA_W = 96;
	localparam int OUT_USER_W = 2;

	localparam int ROW_W     = 6;
	localparam int CHANNEL_W = 5;
	localparam int FX_W      = 64;

	localparam logic [7:0] EMPTY_BYTE  = 8'hFF;
	localparam logic [7:0] NOTE_MASK   = 8'h7F;
	localparam logic [4:0] EFFECT_MASK = 5'h1F;

	typedef enum logic [2:0] {
		PH_LEN_LO,
		PH_LEN_HI,
		PH_FLAG,
		PH_NOTE,
		PH_SAMPLE,
		PH_FX_SEL,
		PH_FX_PARAM
	} phase_t;

	typedef struct packed {
		logic row_overflow;
		logic cell_valid;
	} res_flags_t;

endpackage

@@ rtl/gdm_pattern_unpacker.sv @@
// packed pattern unpacker for a byte stream
// s_axis: one stream byte per transaction; two length bytes (low first) open each
//   pattern, the stored length is that word minus 2 (16-bit wrap), then flag bytes
//   with their note, sample and effect bytes follow
// m_axis: one transaction per completed cell, per suppressed cell (row past the
//   last row) or per pattern end; tlast marks pattern end, tuser carries
//   cell_valid and row_overflow, fields of a suppressed cell read as zero
// path: a byte is held in the input register and its result is held in the
//   output register until the receiver takes it
// throughput: one byte per cycle unless the output stalls; the whole parse state
//   update is one pass of logic between the input register and the output register
// bytes that give no result put no transaction into the output register
// when the receiver stalls the output register holds its transaction, one more
//   byte is taken into the input register if it is empty and then s_axis_tready drops
// reset clears the valid bits of both registers and returns the parser to awaiting
//   a length low byte with an empty cell
module gdm_pattern_unpacker #(
	parameter int ROWS = gdmpu_pkg::GDMPU_ROWS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// data_byte
	input  logic [gdmpu_pkg::IN_DATA_W-1:0] s_axis_tdata,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// row[5:0], channel[10:6], note[18:11], sample[26:19],
	// effects_low[58:27], effects_high[90:59], zero fill
	output logic [gdmpu_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	// pattern_end
	output logic                            m_axis_tlast,
	// cell_valid[0], row_overflow[1]
	output logic [gdmpu_pkg::OUT_USER_W-1:0] m_axis_tuser
);
	import gdmpu_pkg::*;

	localparam int RowCntW = $clog2(ROWS + 1);
	localparam logic [RowCntW-1:0] RowsLim = RowCntW'(ROWS);

	// input register
	logic                 in_valid_s1;
	logic [7:0]           data_s1;

	// parse state
	phase_t               phase_q, phase_n;
	logic [7:0]           len_low_q, len_low_n;
	logic [15:0]          pat_len_q, pat_len_n;
	logic [15:0]          byte_cnt_q, byte_cnt_n;
	logic [RowCntW-1:0]   row_cnt_q, row_cnt_n;
	logic [CHANNEL_W-1:0] channel_q, channel_n;
	logic [1:0]           flag_bits_q, flag_bits_n;
	logic [7:0]           note_q, note_n;
	logic [7:0]           sample_q, sample_n;
	logic [FX_W-1:0]      fx_q, fx_n;
	logic [1:0]           fx_slot_q, fx_slot_n;
	logic                 fx_more_q, fx_more_n;

	// output register
	logic                  out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;
	logic                  out_last_q;
	res_flags_t            out_flags_q;

	logic advance;
	logic process;
	logic boundary;
	logic complete;
	logic res_cell;
	logic res_ovf;
	logic res_end;
	logic [OUT_DATA_W-1:0] res_data;

	assign advance       = !out_valid_q || m_axis_tready;
	assign process       = in_valid_s1 && advance;
	assign s_axis_tready = !in_valid_s1 || advance;

	always_comb begin
		phase_n     = phase_q;
		len_low_n   = len_low_q;
		pat_len_n   = pat_len_q;
		byte_cnt_n  = byte_cnt_q;
		row_cnt_n   = row_cnt_q;
		channel_n   = channel_q;
		flag_bits_n = flag_bits_q;
		note_n      = note_q;
		sample_n    = sample_q;
		fx_n        = fx_q;
		fx_slot_n   = fx_slot_q;
		fx_more_n   = fx_more_q;
		boundary    = 1'b0;
		complete    = 1'b0;
		res_end     = 1'b0;
		res_cell    = 1'b0;
		res_ovf     = 1'b0;

		unique case (phase_q)
			PH_LEN_LO: begin
				len_low_n = data_s1;
				phase_n   = PH_LEN_HI;
			end
			PH_LEN_HI: begin
				pat_len_n  = {data_s1, len_low_q} - 16'd2;
				byte_cnt_n = '0;
				row_cnt_n  = '0;
				if (pat_len_n == 16'd0) begin
					res_end = 1'b1;
					phase_n = PH_LEN_LO;
				end else begin
					phase_n = PH_FLAG;
				end
			end
			PH_FLAG: begin
				byte_cnt_n  = byte_cnt_q + 16'd1;
				note_n      = EMPTY_BYTE;
				sample_n    = EMPTY_BYTE;
				fx_n        = '1;
				channel_n   = data_s1[4:0];
				flag_bits_n = data_s1[6:5];
				if (data_s1 == 8'd0) begin
					if (row_cnt_q < RowsLim) begin
						row_cnt_n = row_cnt_q + RowCntW'(1);
					end
					boundary = 1'b1;
				end else if (data_s1[6:5] == 2'b00) begin
					// flag with no payload still closes a cell
					boundary = 1'b1;
				end else if (data_s1[5]) begin
					phase_n = PH_NOTE;
				end else begin
					phase_n = PH_FX_SEL;
				end
			end
			PH_NOTE: begin
				byte_cnt_n = byte_cnt_q + 16'd1;
				note_n     = data_s1 & NOTE_MASK;
				phase_n    = PH_SAMPLE;
			end
			PH_SAMPLE: begin
				byte_cnt_n = byte_cnt_q + 16'd1;
				sample_n   = data_s1;
				if (flag_bits_q[1]) begin
					phase_n = PH_FX_SEL;
				end else begin
					complete = 1'b1;
				end
			end
			PH_FX_SEL: begin
				byte_cnt_n = byte_cnt_q + 16'd1;
				fx_slot_n  = data_s1[7:6];
				fx_more_n  = data_s1[5];
				fx_n[{data_s1[7:6], 4'd0} +: 8] = {3'd0, data_s1[4:0] & EFFECT_MASK};
				phase_n    = PH_FX_PARAM;
			end
			PH_FX_PARAM: begin
				byte_cnt_n = byte_cnt_q + 16'd1;
				fx_n[{fx_slot_q, 4'd8} +: 8] = data_s1;
				if (fx_more_q) begin
					phase_n = PH_FX_SEL;
				end else begin
					complete = 1'b1;
				end
			end
			default: begin
				phase_n = PH_LEN_LO;
			end
		endcase

		if (complete) begin
			// rows past the last one are reported but the cell is dropped
			if (row_cnt_n >= RowsLim) begin
				res_ovf = 1'b1;
			end else begin
				res_cell = 1'b1;
			end
			boundary = 1'b1;
		end
		if (boundary) begin
			phase_n = PH_FLAG;
			if (byte_cnt_n >= pat_len_n) begin
				res_end = 1'b1;
				phase_n = PH_LEN_LO;
			end
		end
	end

	always_comb begin
		res_data = '0;
		if (res_cell) begin
			res_data[5:0]   = ROW_W'(row_cnt_n);
			res_data[10:6]  = channel_n;
			res_data[18:11] = note_n;
			res_data[26:19] = sample_n;
			res_data[90:27] = fx_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			in_valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready) begin
			data_s1 <= s_axis_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_LEN_LO;
			len_low_q   <= '0;
			pat_len_q   <= '0;
			byte_cnt_q  <= '0;
			row_cnt_q   <= '0;
			channel_q   <= '0;
			flag_bits_q <= '0;
			note_q      <= EMPTY_BYTE;
			sample_q    <= EMPTY_BYTE;
			fx_q        <= '1;
			fx_slot_q   <= '0;
			fx_more_q   <= 1'b0;
		end else if (process) begin
			phase_q     <= phase_n;
			len_low_q   <= len_low_n;
			pat_len_q   <= pat_len_n;
			byte_cnt_q  <= byte_cnt_n;
			row_cnt_q   <= row_cnt_n;
			channel_q   <= channel_n;
			flag_bits_q <= flag_bits_n;
			note_q      <= note_n;
			sample_q    <= sample_n;
			fx_q        <= fx_n;
			fx_slot_q   <= fx_slot_n;
			fx_more_q   <= fx_more_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= process && (res_cell || res_ovf || res_end);
		end
	end

	always_ff @(posedge clk) begin
		if (process) begin
			out_data_q               <= res_data;
			out_last_q               <= res_end;
			out_flags_q.cell_valid   <= res_cell;
			out_flags_q.row_overflow <= res_ovf;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tuser  = out_flags_q;

endmodule
